/* hdl/clfd_pkg.sv */
// Shared types, defaults and microcode program for the cubic Lagrange fractional-delay block.
package clfd_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 15;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_HORNER,
		OP_PREP,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		COEF_A2,
		COEF_A1,
		COEF_A0
	} coef_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_IN_WORD,
		COND_OUT_FREE
	} cond_t;

	typedef logic [2:0] upc_t;

	localparam upc_t UPC_IDLE   = 3'd0;
	localparam upc_t UPC_H3     = 3'd1;
	localparam upc_t UPC_H2     = 3'd2;
	localparam upc_t UPC_H1     = 3'd3;
	localparam upc_t UPC_PREP   = 3'd4;
	localparam upc_t UPC_FINISH = 3'd5;

	typedef struct packed {
		op_t   op;
		logic  src_acc;
		coef_t coef;
		cond_t cond;
		upc_t  target;
	} ucode_word_t;

	typedef struct packed {
		logic  load;
		logic  horner;
		logic  src_acc;
		coef_t coef;
		logic  prep;
		logic  finish;
	} ctrl_t;

	function automatic ucode_word_t ucode_rom(input upc_t pc);
		ucode_word_t w;
		w.op      = OP_LOAD;
		w.src_acc = 1'b0;
		w.coef    = COEF_A2;
		w.cond    = COND_ALWAYS;
		w.target  = UPC_IDLE;
		case (pc)
			UPC_IDLE: begin
				w.cond   = COND_IN_WORD;
				w.target = UPC_H3;
			end
			UPC_H3: begin
				w.op     = OP_HORNER;
				w.coef   = COEF_A2;
				w.target = UPC_H2;
			end
			UPC_H2: begin
				w.op      = OP_HORNER;
				w.src_acc = 1'b1;
				w.coef    = COEF_A1;
				w.target  = UPC_H1;
			end
			UPC_H1: begin
				w.op      = OP_HORNER;
				w.src_acc = 1'b1;
				w.coef    = COEF_A0;
				w.target  = UPC_PREP;
			end
			UPC_PREP: begin
				w.op     = OP_PREP;
				w.target = UPC_FINISH;
			end
			UPC_FINISH: begin
				w.op     = OP_FINISH;
				w.cond   = COND_OUT_FREE;
				w.target = UPC_IDLE;
			end
			default: begin
				w.target = UPC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

/* hdl/cubic_lagrange_fractional_delay.sv */
// Top level of the cubic Lagrange fractional-delay interpolator.
//
// Input channel: in_valid / in_stall with the signed sample. A word is taken
// when in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall with the signed interpolated sample delayed, one word per input word.
// cfg_write_en / cfg_write_data write the fractional delay mu (unsigned, FRAC_BITS
// fraction bits); write it only while the block is idle.
//
// Each input word is worked through three Horner steps, a divide-by-six prepare
// step and a finish step, run by the microcode program that passes all Horner
// steps through a single shared multiplier. The input stays stalled until the
// finish step is done, so a new word is taken only after the last one finishes.
//
// Reset clears the three-sample history to zero, sets mu to one quarter sample
// and empties the output register. While out_stall is high, the finished word
// holds in the output register; the next word may be taken and worked on, and
// its finish step waits until the output register is free.
module cubic_lagrange_fractional_delay #(
	parameter int SAMPLE_BITS = clfd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = clfd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] delayed,
	input  logic                          cfg_write_en,
	input  logic        [FRAC_BITS-1:0]   cfg_write_data
);

	clfd_pkg::ctrl_t ctrl;

	clfd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	clfd_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.sample         (sample),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.delayed        (delayed)
	);

endmodule

/* hdl/clfd_seq.sv */
// Microcode sequencer: step counter, program table lookup and output valid.
module clfd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output clfd_pkg::ctrl_t ctrl
);

	clfd_pkg::upc_t        pc_q;
	clfd_pkg::upc_t        pc_d;
	clfd_pkg::ucode_word_t word;
	logic                  out_valid_q;
	logic                  out_valid_d;
	logic                  out_free;
	logic                  cond_true;

	assign word     = clfd_pkg::ucode_rom(pc_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (word.cond)
			clfd_pkg::COND_ALWAYS:   cond_true = 1'b1;
			clfd_pkg::COND_IN_WORD:  cond_true = in_valid;
			clfd_pkg::COND_OUT_FREE: cond_true = out_free;
			default:                 cond_true = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = cond_true ? word.target : pc_q;
	end

	always_comb begin
		ctrl.load    = (word.op == clfd_pkg::OP_LOAD) && in_valid;
		ctrl.horner  = (word.op == clfd_pkg::OP_HORNER);
		ctrl.src_acc = word.src_acc;
		ctrl.coef    = word.coef;
		ctrl.prep    = (word.op == clfd_pkg::OP_PREP);
		ctrl.finish  = (word.op == clfd_pkg::OP_FINISH) && out_free;
		in_stall     = (word.op != clfd_pkg::OP_LOAD);
		out_valid_d  = out_valid_q;
		if (ctrl.finish) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= clfd_pkg::UPC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q        <= pc_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/clfd_datapath.sv */
// Datapath: sample history, coefficient forming, shared Horner multiplier and divide-by-six.
module clfd_datapath #(
	parameter int SAMPLE_BITS = clfd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = clfd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  clfd_pkg::ctrl_t               ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          cfg_write_en,
	input  logic        [FRAC_BITS-1:0]   cfg_write_data,
	output logic signed [SAMPLE_BITS-1:0] delayed
);

	localparam int CW = SAMPLE_BITS + 8;
	localparam int PW = CW + FRAC_BITS + 1;
	localparam int NW = SAMPLE_BITS + 3;
	localparam int RW = SAMPLE_BITS + 4;
	localparam int QS = SAMPLE_BITS + 6;
	localparam logic        [RW-1:0]          RECIP     = RW'(((64'd1 << QS) + 64'd5) / 64'd6);
	localparam logic signed [CW-1:0]          SAT_BOUND = CW'(64'd3 << SAMPLE_BITS);
	localparam logic signed [CW-1:0]          THREE     = CW'(64'd3);
	localparam logic signed [PW-1:0]          HALF      = PW'(64'd1 << (FRAC_BITS - 1));
	localparam logic        [FRAC_BITS-1:0]   MU_RESET  = FRAC_BITS'(64'd1 << (FRAC_BITS - 2));
	localparam logic signed [SAMPLE_BITS-1:0] Y_MAX     = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] Y_MIN     = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] h0_q, h1_q, h2_q;
	logic        [FRAC_BITS-1:0]   mu_q;
	logic signed [CW-1:0]          a3_q, a2_q, a1_q, a0_q, acc_q;
	logic        [NW-1:0]          n_q;
	logic                          sat_hi_q, sat_lo_q;
	logic signed [SAMPLE_BITS-1:0] delayed_q;

	logic signed [CW-1:0]          w0, w1, w2, w3;
	logic signed [CW-1:0]          d30, d12, d31, s2;
	logic signed [CW-1:0]          a3, a2, a1, a0;
	logic signed [CW-1:0]          src, coef, acc_d;
	logic signed [FRAC_BITS:0]     mu_s;
	logic signed [PW-1:0]          prod, rnd;
	logic signed [CW-1:0]          v, nsum;
	logic        [NW+RW-1:0]       prod2;
	logic        [SAMPLE_BITS-1:0] q;
	logic signed [SAMPLE_BITS-1:0] y;

	always_comb begin
		w0  = CW'(h0_q);
		w1  = CW'(h1_q);
		w2  = CW'(h2_q);
		w3  = CW'(sample);
		d30 = w3 - w0;
		d12 = w1 - w2;
		d31 = w3 - w1;
		s2  = w3 + w1 - (w2 <<< 1);
		a3  = d30 + d12 + (d12 <<< 1);
		a1  = d31 + (d31 <<< 1) - a3;
		a2  = s2 + (s2 <<< 1);
		a0  = (w2 <<< 1) + (w2 <<< 2);
	end

	always_comb begin
		src  = ctrl.src_acc ? acc_q : a3_q;
		mu_s = signed'({1'b0, mu_q});
		prod = src * mu_s;
		rnd  = (HALF - prod) >>> FRAC_BITS;
		case (ctrl.coef)
			clfd_pkg::COEF_A2: coef = a2_q;
			clfd_pkg::COEF_A1: coef = a1_q;
			clfd_pkg::COEF_A0: coef = a0_q;
			default:           coef = a0_q;
		endcase
		acc_d = coef + signed'(rnd[CW-1:0]);
	end

	always_comb begin
		v    = acc_q + THREE;
		nsum = v + SAT_BOUND;
	end

	always_comb begin
		prod2 = (NW + RW)'(n_q) * (NW + RW)'(RECIP);
		q     = prod2[QS +: SAMPLE_BITS];
		y     = signed'({~q[SAMPLE_BITS-1], q[SAMPLE_BITS-2:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q <= '0;
			h1_q <= '0;
			h2_q <= '0;
			mu_q <= MU_RESET;
		end else begin
			if (cfg_write_en) begin
				mu_q <= cfg_write_data;
			end
			if (ctrl.load) begin
				h0_q <= h1_q;
				h1_q <= h2_q;
				h2_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a3_q <= a3;
			a2_q <= a2;
			a1_q <= a1;
			a0_q <= a0;
		end
		if (ctrl.horner) begin
			acc_q <= acc_d;
		end
		if (ctrl.prep) begin
			n_q      <= nsum[NW-1:0];
			sat_hi_q <= (v >= SAT_BOUND);
			sat_lo_q <= (v < -SAT_BOUND);
		end
		if (ctrl.finish) begin
			if (sat_hi_q) begin
				delayed_q <= Y_MAX;
			end else if (sat_lo_q) begin
				delayed_q <= Y_MIN;
			end else begin
				delayed_q <= y;
			end
		end
	end

	assign delayed = delayed_q;

endmodule

/* hdl/clfd_checker.sv */
// Port-level assertions for the fractional-delay block and their bind.
module clfd_checker #(
	parameter int SAMPLE_BITS = clfd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = clfd_pkg::FRAC_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] delayed,
	input logic                          cfg_write_en,
	input logic        [FRAC_BITS-1:0]   cfg_write_data
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after taking a word");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample))
		else $error("stalled input word changed");

	a_done_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("sequencer went idle without a result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(delayed))
		else $error("stalled output word changed");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |-> !in_stall && !out_valid && !$isunknown(cfg_write_data))
		else $error("mu written while a word was in flight");

endmodule

bind cubic_lagrange_fractional_delay clfd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.FRAC_BITS   (FRAC_BITS)
) u_clfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.sample         (sample),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.delayed        (delayed),
	.cfg_write_en   (cfg_write_en),
	.cfg_write_data (cfg_write_data)
);

/* dv/tb_cubic_lagrange_fractional_delay.sv */
// Self-checking testbench for the cubic Lagrange fractional-delay interpolator.
`timescale 1ns / 100ps

module tb_cubic_lagrange_fractional_delay;

	localparam int SW = clfd_pkg::SAMPLE_BITS_DEF;
	localparam int FW = clfd_pkg::FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORDS_PER_RUN = 150;
	localparam logic [FW-1:0] MU_RESET = FW'(1 << (FW - 2));
	localparam int MU_RANDOM = -1;

	class lagrange_scoreboard;
		logic [FW-1:0] mu;
		longint hist[3];
		logic signed [SW-1:0] expected_delayed[$];
		int errors;

		function new();
			mu = MU_RESET;
			foreach (hist[i]) hist[i] = 0;
			errors = 0;
		endfunction

		function longint round_q(longint x);
			return (x + (longint'(1) << (FW - 1))) >>> FW;
		endfunction

		function longint div6_round(longint x);
			longint v;
			v = x + 3;
			if (v >= 0)
				return v / 6;
			return -((-v + 5) / 6);
		endfunction

		function logic signed [SW-1:0] interpolate(longint w3);
			longint m, a3, a2, a1, a0, t, y, hi, lo;
			m  = longint'(mu);
			hi = (longint'(1) << (SW - 1)) - 1;
			lo = -(longint'(1) << (SW - 1));
			a3 = (w3 - hist[0]) + 3 * (hist[1] - hist[2]);
			a1 = 3 * (w3 - hist[1]) - a3;
			a2 = 6 * (w3 - hist[2]) - a3 - a1;
			a0 = 6 * hist[2];
			t = a2 + round_q(-(a3 * m));
			t = a1 + round_q(-(t * m));
			t = a0 + round_q(-(t * m));
			y = div6_round(t);
			if (y > hi) y = hi;
			if (y < lo) y = lo;
			return y[SW-1:0];
		endfunction

		function void take_sample(logic signed [SW-1:0] s);
			expected_delayed.push_back(interpolate(longint'(s)));
			hist[0] = hist[1];
			hist[1] = hist[2];
			hist[2] = longint'(s);
		endfunction

		function void check_delayed(logic signed [SW-1:0] got);
			logic signed [SW-1:0] want;
			if (expected_delayed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("delayed word %0d arrived with nothing pending", got);
				return;
			end
			want = expected_delayed.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("delayed mismatch: expected %0d, got %0d (mu %0d)", want, got, mu);
			end
		endfunction

		function int pending();
			return expected_delayed.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] delayed;
	logic cfg_write_en = 1'b0;
	logic [FW-1:0] cfg_write_data = '0;

	lagrange_scoreboard sb = new();
	bit steady = 1'b0;
	int cycle_count = 0;

	int mu_plan[10] = '{0, 32767, 16384, 1, 32766, MU_RANDOM, 24576,
		MU_RANDOM, 4096, MU_RANDOM};
	logic signed [SW-1:0] startup[10] = '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000};
	logic signed [SW-1:0] overshoot[8] = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
		16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};

	cubic_lagrange_fractional_delay u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.delayed(delayed),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_delayed(delayed);
		out_stall <= !steady && ($urandom_range(99) < 31);
	end

	task automatic send_word(input logic signed [SW-1:0] s);
		while (!steady && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.take_sample(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_mu(input logic [FW-1:0] v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.mu = v;
	endtask

	task automatic random_run(input int n);
		int style, level, i;
		logic [SW-1:0] s;
		style = 0;
		level = 0;
		for (i = 0; i < n; i++) begin
			if (i % 16 == 0)
				style = $urandom_range(3);
			case (style)
				0: s = SW'($urandom);
				1: begin
					level = level + int'($urandom_range(4000)) - 2000;
					if (level > 32767) level = 32767;
					if (level < -32768) level = -32768;
					s = level[SW-1:0];
				end
				2: s = $urandom_range(1) ? SW'(16'h7fff - $urandom_range(255))
					: SW'(16'h8000 + $urandom_range(255));
				default: s = i[0] ? SW'(16'h7fff - $urandom_range(63))
					: SW'(16'h8000 + $urandom_range(63));
			endcase
			send_word(s);
		end
	endtask

	initial begin
		int p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (startup[i]) send_word(startup[i]);
		random_run(WORDS_PER_RUN);
		drain();

		for (p = 0; p < 10; p++) begin
			if (mu_plan[p] == MU_RANDOM)
				write_mu(FW'($urandom_range(32767)));
			else
				write_mu(FW'(mu_plan[p]));
			steady = (p == 3);
			if (mu_plan[p] == 16384)
				foreach (overshoot[i]) send_word(overshoot[i]);
			if (mu_plan[p] == 0 || mu_plan[p] == 32767) begin
				send_word(16'sh7fff);
				send_word(16'sh8000);
				send_word(16'sh7fff);
			end
			random_run(WORDS_PER_RUN);
			drain();
			steady = 1'b0;
		end

		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
